/* rtl/core/tgarle_pkg.sv */
// shared types and constants for the truecolor tga rle decoder core
// no dependencies; imported by every module of the core
package tgarle_pkg;

  // result kinds
  localparam logic [1:0] KIND_PIXEL    = 2'd0;
  localparam logic [1:0] KIND_HEADER   = 2'd1;
  localparam logic [1:0] KIND_BAD_SIG  = 2'd2;
  localparam logic [1:0] KIND_BAD_SIZE = 2'd3;

  // header byte positions
  localparam int unsigned HPOS_W = 5;
  localparam logic [HPOS_W-1:0] HPOS_SIG_END  = 5'd12;
  localparam logic [HPOS_W-1:0] HPOS_WIDTH_LO = 5'd12;
  localparam logic [HPOS_W-1:0] HPOS_WIDTH_HI = 5'd13;
  localparam logic [HPOS_W-1:0] HPOS_HEIGHT_LO = 5'd14;
  localparam logic [HPOS_W-1:0] HPOS_HEIGHT_HI = 5'd15;
  localparam logic [HPOS_W-1:0] HPOS_DEPTH    = 5'd16;
  localparam logic [HPOS_W-1:0] HPOS_LAST     = 5'd17;

  localparam logic [HPOS_W-1:0] SIG_TYPE_POS  = 5'd2;
  localparam logic [7:0]        SIG_TYPE_RLE  = 8'h0A;

  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 112;
  localparam int unsigned OUT_PAD_W   = 6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_res;
    logic [31:0] pixel_index;
    logic        last;
    logic        overrun;
    logic [15:0] width;
    logic [15:0] height;
    logic        has_alpha;
  } res_t;

  // expected signature byte: all zero except the image type byte
  function automatic logic [7:0] sig_byte(input logic [HPOS_W-1:0] pos);
    logic [7:0] v;
    v = 8'h00;
    if (pos == SIG_TYPE_POS) begin
      v = SIG_TYPE_RLE;
    end
    return v;
  endfunction

endpackage

/* rtl/core/tga_rle_image_decoder_core.sv */
// truecolor tga rle decoder core: one file byte per beat in, header/error/pixel results out
// a byte goes from the input register through the parser into the result register
// one byte per cycle unless the sink stalls; per-byte state update is one registered step
// reset (rst_n low, synchronous): parser back to header byte 0, both stages emptied
// depends on tgarle_pkg, tgarle_in_stage, tgarle_parser, tgarle_out_stage
module tga_rle_image_decoder_core
  import tgarle_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]             in_tuser,   // [0] first
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [39:32] repeat_res,
  // [71:40] pixel_index, [72] overrun, [88:73] width, [104:89] height,
  // [105] has_alpha, [111:106] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser,  // [1:0] kind
  output logic                   out_tlast   // last
);

  item_t item;
  logic  item_valid;
  logic  free;
  logic  advance;
  logic  res_valid;
  res_t  res;

  // a byte moves on whenever the result register can take what it produces
  assign advance = item_valid && free;

  tgarle_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  tgarle_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  tgarle_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .res_valid  (res_valid),
    .res        (res),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* rtl/core/tgarle_in_stage.sv */
// input register of the tga rle decoder core
// holds one accepted byte beat until the parser takes it; uses tgarle_pkg
module tgarle_in_stage
  import tgarle_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // [7:0] data_byte
  input  logic [0:0]            in_tuser,   // [0] first
  input  logic                  advance,
  output logic                  item_valid,
  output item_t                 item
);

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  load;

  assign in_tready = !valid_r || advance;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (load) begin
      valid_nxt          = 1'b1;
      item_nxt.data_byte = in_tdata;
      item_nxt.first     = in_tuser[0];
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* rtl/core/tgarle_parser.sv */
// header check and packet/pixel decoding of the tga rle decoder core
// keeps the parse state, forms at most one result per byte; uses tgarle_pkg
module tgarle_parser
  import tgarle_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  advance,
  input  item_t item,
  output logic  res_valid,
  output res_t  res
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_PKT    = 2'd1;
  localparam logic [1:0] PH_PIXEL  = 2'd2;
  localparam logic [1:0] PH_IDLE   = 2'd3;

  logic [1:0]        phase_r, phase_nxt;
  logic [HPOS_W-1:0] hpos_r, hpos_nxt;
  logic              sig_ok_r, sig_ok_nxt;
  logic [15:0]       width_r, width_nxt;
  logic [15:0]       height_r, height_nxt;
  logic              alpha_r, alpha_nxt;
  logic [31:0]       total_r, total_nxt;
  logic [31:0]       done_r, done_nxt;
  logic [7:0]        pleft_r, pleft_nxt;
  logic              prun_r, prun_nxt;
  logic [1:0]        bip_r, bip_nxt;
  logic [7:0]        pb0_r, pb0_nxt;
  logic [7:0]        pb1_r, pb1_nxt;
  logic [7:0]        pb2_r, pb2_nxt;
  logic              clamp_r, clamp_nxt;

  // state as seen by this byte: a first byte restarts from reset values
  logic [1:0]        ph;
  logic [HPOS_W-1:0] hpos;
  logic [15:0]       w, h;
  logic              am;
  logic [31:0]       total, done;
  logic [7:0]        pleft, pb0;
  logic [1:0]        bip;
  logic [7:0]        b;

  logic [31:0] left;
  logic [7:0]  count;
  logic [7:0]  rep;
  logic [31:0] done_sum;
  logic [1:0]  bip_end;

  assign b     = item.data_byte;
  assign ph    = item.first ? PH_HEADER : phase_r;
  assign hpos  = item.first ? '0 : hpos_r;
  assign w     = item.first ? 16'd0 : width_r;
  assign h     = item.first ? 16'd0 : height_r;
  assign am    = item.first ? 1'b0 : alpha_r;
  assign total = item.first ? 32'd0 : total_r;
  assign done  = item.first ? 32'd0 : done_r;
  assign pleft = item.first ? 8'd0 : pleft_r;
  assign bip   = item.first ? 2'd0 : bip_r;
  assign pb0   = item.first ? 8'd0 : pb0_r;

  assign left     = total - done;
  assign count    = {1'b0, b[6:0]} + 8'd1;
  // only used in the pixel phase, where a first byte never arrives
  assign rep      = prun_r ? pleft : 8'd1;
  assign done_sum = done + {24'd0, rep};
  assign bip_end  = am ? 2'd3 : 2'd2;

  always_comb begin
    phase_nxt  = ph;
    hpos_nxt   = hpos;
    sig_ok_nxt = item.first ? 1'b1 : sig_ok_r;
    width_nxt  = w;
    height_nxt = h;
    alpha_nxt  = am;
    total_nxt  = total;
    done_nxt   = done;
    pleft_nxt  = pleft;
    prun_nxt   = item.first ? 1'b0 : prun_r;
    bip_nxt    = bip;
    pb0_nxt    = pb0;
    pb1_nxt    = item.first ? 8'd0 : pb1_r;
    pb2_nxt    = item.first ? 8'd0 : pb2_r;
    clamp_nxt  = item.first ? 1'b0 : clamp_r;

    res_valid = 1'b0;
    res       = '0;

    case (ph)
      PH_HEADER: begin
        if (hpos < HPOS_SIG_END) begin
          if (b != sig_byte(hpos)) begin
            sig_ok_nxt = 1'b0;
          end
        end else if (hpos == HPOS_WIDTH_LO) begin
          width_nxt[7:0] = b;
        end else if (hpos == HPOS_WIDTH_HI) begin
          width_nxt[15:8] = b;
        end else if (hpos == HPOS_HEIGHT_LO) begin
          height_nxt[7:0] = b;
        end else if (hpos == HPOS_HEIGHT_HI) begin
          height_nxt[15:8] = b;
        end else if (hpos == HPOS_DEPTH) begin
          pb0_nxt   = b;
          alpha_nxt = (b == DEPTH_32);
        end
        if (hpos < HPOS_LAST) begin
          hpos_nxt = hpos + HPOS_W'(1);
        end else begin
          res_valid = 1'b1;
          phase_nxt = PH_IDLE;
          if (!sig_ok_nxt) begin
            res.kind = KIND_BAD_SIG;
          end else if (w == 16'd0 || h == 16'd0 ||
                       (pb0 != DEPTH_24 && pb0 != DEPTH_32)) begin
            res.kind = KIND_BAD_SIZE;
          end else begin
            res.kind  = KIND_HEADER;
            total_nxt = {16'd0, w} * {16'd0, h};
            done_nxt  = 32'd0;
            pb0_nxt   = 8'd0;
            phase_nxt = PH_PKT;
          end
        end
      end
      PH_PKT: begin
        prun_nxt  = b[7];
        clamp_nxt = {24'd0, count} > left;
        pleft_nxt = clamp_nxt ? left[7:0] : count;
        bip_nxt   = 2'd0;
        phase_nxt = PH_PIXEL;
      end
      PH_PIXEL: begin
        case (bip)
          2'd0: pb0_nxt = b;
          2'd1: pb1_nxt = b;
          2'd2: pb2_nxt = b;
          default: ;
        endcase
        if (bip != bip_end) begin
          bip_nxt = bip + 2'd1;
        end else begin
          bip_nxt         = 2'd0;
          res_valid       = 1'b1;
          res.kind        = KIND_PIXEL;
          res.red         = pb2_nxt;
          res.green       = pb1_nxt;
          res.blue        = pb0_nxt;
          res.alpha       = am ? b : 8'd0;
          res.repeat_res  = rep;
          res.pixel_index = done;
          res.overrun     = clamp_nxt;
          done_nxt        = done_sum;
          pleft_nxt       = pleft - rep;
          if (done_sum >= total) begin
            res.last  = 1'b1;
            phase_nxt = PH_IDLE;
          end else if (pleft_nxt == 8'd0) begin
            phase_nxt = PH_PKT;
          end
        end
      end
      default: ;
    endcase

    res.width     = width_nxt;
    res.height    = height_nxt;
    res.has_alpha = alpha_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      hpos_r   <= '0;
      sig_ok_r <= 1'b1;
      width_r  <= 16'd0;
      height_r <= 16'd0;
      alpha_r  <= 1'b0;
      total_r  <= 32'd0;
      done_r   <= 32'd0;
      pleft_r  <= 8'd0;
      prun_r   <= 1'b0;
      bip_r    <= 2'd0;
      pb0_r    <= 8'd0;
      pb1_r    <= 8'd0;
      pb2_r    <= 8'd0;
      clamp_r  <= 1'b0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      hpos_r   <= hpos_nxt;
      sig_ok_r <= sig_ok_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      alpha_r  <= alpha_nxt;
      total_r  <= total_nxt;
      done_r   <= done_nxt;
      pleft_r  <= pleft_nxt;
      prun_r   <= prun_nxt;
      bip_r    <= bip_nxt;
      pb0_r    <= pb0_nxt;
      pb1_r    <= pb1_nxt;
      pb2_r    <= pb2_nxt;
      clamp_r  <= clamp_nxt;
    end
  end

endmodule

/* rtl/core/tgarle_out_stage.sv */
// result register of the tga rle decoder core
// holds one result beat until the sink takes it; uses tgarle_pkg
module tgarle_out_stage
  import tgarle_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  logic                   res_valid,
  input  res_t                   res,
  output logic                   free,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [39:32] repeat_res,
  // [71:40] pixel_index, [72] overrun, [88:73] width, [104:89] height,
  // [105] has_alpha, [111:106] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser,  // [1:0] kind
  output logic                   out_tlast   // last
);

  logic valid_r, valid_nxt;
  res_t res_r;

  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = res_valid;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, res_r.has_alpha, res_r.height, res_r.width,
                       res_r.overrun, res_r.pixel_index, res_r.repeat_res,
                       res_r.alpha, res_r.blue, res_r.green, res_r.red};
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last;

endmodule

/* bench/testbench.sv */
// self-checking bench for tga_rle_image_decoder_core: byte stream in, header/pixel beats out
// carries its own model of the decoder and compares every result beat field by field
// depends on tgarle_pkg and the core rtl
`timescale 1ns / 100ps

module testbench;
  import tgarle_pkg::*;

  typedef enum logic [1:0] {
    P_HEADER,
    P_PACKET,
    P_PIXEL,
    P_DONE
  } parse_phase_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [0:0]             in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tlast;

  tga_rle_image_decoder_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  item_t pending_bytes[$];
  res_t  awaited_results[$];
  int    bytes_sent   = 0;
  int    results_seen = 0;
  int    mismatches   = 0;
  bit    hold_off     = 1'b0;
  wire   steady = (bytes_sent >= 600) && (bytes_sent < 1000);

  // decoder model state
  parse_phase_t prs_phase;
  logic [4:0]   hdr_pos;
  logic         sig_good;
  logic [15:0]  img_w;
  logic [15:0]  img_h;
  logic         alpha_on;
  logic [31:0]  pix_total;
  logic [31:0]  pix_done;
  logic [7:0]   pkt_left;
  logic         pkt_run;
  logic [1:0]   byte_pos;
  logic [7:0]   pix_b [0:2];
  logic         pkt_clamped;

  task automatic decoder_clear();
    prs_phase   = P_HEADER;
    hdr_pos     = '0;
    sig_good    = 1'b1;
    img_w       = '0;
    img_h       = '0;
    alpha_on    = 1'b0;
    pix_total   = '0;
    pix_done    = '0;
    pkt_left    = '0;
    pkt_run     = 1'b0;
    byte_pos    = '0;
    pix_b[0]    = '0;
    pix_b[1]    = '0;
    pix_b[2]    = '0;
    pkt_clamped = 1'b0;
  endtask

  task automatic decode_byte(input item_t it, output bit got, output res_t r);
    logic [7:0]  b;
    logic [31:0] left;
    logic [31:0] cnt;
    logic [31:0] rep;
    logic [2:0]  need;
    logic [4:0]  pos;
    logic [1:0]  bpos;
    b   = it.data_byte;
    got = 1'b0;
    r   = '0;
    if (it.first) decoder_clear();
    case (prs_phase)
      P_HEADER: begin
        pos = hdr_pos;
        if (pos < HPOS_SIG_END) begin
          if (b != ((pos == SIG_TYPE_POS) ? SIG_TYPE_RLE : 8'h00)) sig_good = 1'b0;
        end else if (pos == HPOS_WIDTH_LO) begin
          img_w[7:0] = b;
        end else if (pos == HPOS_WIDTH_HI) begin
          img_w[15:8] = b;
        end else if (pos == HPOS_HEIGHT_LO) begin
          img_h[7:0] = b;
        end else if (pos == HPOS_HEIGHT_HI) begin
          img_h[15:8] = b;
        end else if (pos == HPOS_DEPTH) begin
          pix_b[0] = b;
          alpha_on = (b == DEPTH_32);
        end
        if (pos < HPOS_LAST) begin
          hdr_pos = pos + 5'd1;
        end else begin
          got = 1'b1;
          if (!sig_good) begin
            prs_phase = P_DONE;
            r.kind    = KIND_BAD_SIG;
          end else if (img_w == 16'd0 || img_h == 16'd0 ||
                       (pix_b[0] != DEPTH_24 && pix_b[0] != DEPTH_32)) begin
            prs_phase = P_DONE;
            r.kind    = KIND_BAD_SIZE;
          end else begin
            pix_total = {16'd0, img_w} * {16'd0, img_h};
            pix_done  = '0;
            pix_b[0]  = '0;
            prs_phase = P_PACKET;
            r.kind    = KIND_HEADER;
          end
        end
      end
      P_PACKET: begin
        left    = pix_total - pix_done;
        pkt_run = b[7];
        cnt     = pkt_run ? {25'd0, b[6:0]} + 32'd1 : {24'd0, b} + 32'd1;
        pkt_clamped = (cnt > left);
        if (pkt_clamped) cnt = left;
        pkt_left  = cnt[7:0];
        byte_pos  = '0;
        prs_phase = P_PIXEL;
      end
      P_PIXEL: begin
        need = alpha_on ? 3'd4 : 3'd3;
        bpos = byte_pos;
        if (bpos < 2'd3) pix_b[bpos] = b;
        if ({1'b0, bpos} + 3'd1 < need) begin
          byte_pos = bpos + 2'd1;
        end else begin
          byte_pos      = '0;
          rep           = pkt_run ? {24'd0, pkt_left} : 32'd1;
          got           = 1'b1;
          r.kind        = KIND_PIXEL;
          r.red         = pix_b[2];
          r.green       = pix_b[1];
          r.blue        = pix_b[0];
          r.alpha       = alpha_on ? b : 8'h00;
          r.repeat_res  = rep[7:0];
          r.pixel_index = pix_done;
          r.overrun     = pkt_clamped;
          pix_done      = pix_done + rep;
          pkt_left      = pkt_left - rep[7:0];
          if (pix_done >= pix_total) begin
            r.last    = 1'b1;
            prs_phase = P_DONE;
          end else if (pkt_left == 8'd0) begin
            prs_phase = P_PACKET;
          end
        end
      end
      default: ;
    endcase
    if (got) begin
      r.width     = img_w;
      r.height    = img_h;
      r.has_alpha = alpha_on;
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic push_byte(input logic [7:0] b, input bit first_flag);
    item_t it;
    it.data_byte = b;
    it.first     = first_flag;
    pending_bytes.push_back(it);
  endtask

  // bad_pos < 12 corrupts that signature byte, anything else keeps it clean
  task automatic push_header(input bit first_flag, input logic [15:0] w, input logic [15:0] h,
                             input logic [7:0] depth, input int bad_pos);
    logic [7:0] b;
    for (int i = 0; i < 18; i++) begin
      case (i)
        12:      b = w[7:0];
        13:      b = w[15:8];
        14:      b = h[7:0];
        15:      b = h[15:8];
        16:      b = depth;
        17:      b = 8'($urandom_range(0, 255));
        default: b = (i == SIG_TYPE_POS) ? SIG_TYPE_RLE : 8'h00;
      endcase
      if (i == bad_pos) b = b ^ 8'($urandom_range(1, 255));
      push_byte(b, first_flag && (i == 0));
    end
  endtask

  task automatic push_pixel(input int nbytes, input logic [31:0] v);
    for (int i = 0; i < nbytes; i++) push_byte(v[8*i +: 8], 1'b0);
  endtask

  task automatic push_noise(input int n, input int first_odds);
    for (int i = 0; i < n; i++) begin
      push_byte(8'($urandom_range(0, 255)), $urandom_range(0, first_odds - 1) == 0);
    end
  endtask

  // packets covering a w x h image; may end with an overrunning packet or stop early
  task automatic push_packets(input longint total, input int nbytes, input bit overrun_ok,
                              input bit cut_short);
    longint left;
    int     cnt;
    int     fit;
    bit     run;
    left = total;
    while (left > 0) begin
      if (cut_short && $urandom_range(0, 3) == 0) break;
      cnt = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
      if (!overrun_ok && cnt > left) cnt = int'(left);
      run = 1'($urandom_range(0, 1));
      fit = (cnt > left) ? int'(left) : cnt;
      push_byte(run ? 8'(127 + cnt) : 8'(cnt - 1), 1'b0);
      if (run) begin
        push_pixel(nbytes, $urandom());
      end else begin
        for (int i = 0; i < fit; i++) push_pixel(nbytes, $urandom());
        // leftover bytes of a clamped raw packet are dropped by the parser
        if (cnt > left) push_noise($urandom_range(1, 3), 1000000);
      end
      left = left - fit;
    end
  endtask

  initial begin : stimulus
    int         base;
    int         pick;
    int         nb;
    logic [15:0] w;
    logic [15:0] h;
    logic [7:0]  dep;

    // 2x2 at depth 24, parser starts without a first flag: raw pair, then a run of two
    push_header(1'b0, 16'd2, 16'd2, DEPTH_24, -1);
    push_byte(8'h01, 1'b0);
    push_pixel(3, 32'h0000FF);
    push_pixel(3, 32'hFF0000);
    push_byte(8'h81, 1'b0);
    push_pixel(3, 32'h5A3C96);
    push_noise(2, 1000000);
    // 3x1 at depth 32, all-ones and all-zeros pixels, longest run clamped
    push_header(1'b1, 16'd3, 16'd1, DEPTH_32, -1);
    push_byte(8'h00, 1'b0);
    push_pixel(4, 32'hFFFFFFFF);
    push_byte(8'hFF, 1'b0);
    push_pixel(4, 32'h00000000);
    // longest raw packet clamped to a 2x1 image, tail bytes ignored
    push_header(1'b1, 16'd2, 16'd1, DEPTH_24, -1);
    push_byte(8'h7F, 1'b0);
    push_pixel(3, 32'h123456);
    push_pixel(3, 32'hABCDEF);
    push_noise(3, 1000000);
    // bad signature wins over a bad depth
    push_header(1'b1, 16'd4, 16'd4, 8'd16, SIG_TYPE_POS);
    push_header(1'b1, 16'd4, 16'd4, DEPTH_24, 11);
    // zero width, zero height, odd depth
    push_header(1'b1, 16'd0, 16'd5, DEPTH_24, -1);
    push_header(1'b1, 16'd5, 16'd0, DEPTH_32, -1);
    push_header(1'b1, 16'd1, 16'd1, 8'd25, -1);
    // largest image, a run of 128, then a run pixel with only two of its bytes
    push_header(1'b1, 16'hFFFF, 16'hFFFF, DEPTH_32, -1);
    push_byte(8'hFF, 1'b0);
    push_pixel(4, $urandom());
    push_byte(8'h80, 1'b0);
    push_pixel(2, $urandom());
    // noise carries on in the image's pixel data, then a restart with a new header
    push_noise(7, 1000000);
    push_header(1'b1, 16'd1, 16'd1, DEPTH_24, -1);
    push_byte(8'h80, 1'b0);
    push_pixel(3, $urandom());

    base = pending_bytes.size();
    while (pending_bytes.size() < base + 1500) begin
      pick = $urandom_range(0, 99);
      dep  = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
      nb   = (dep == DEPTH_32) ? 4 : 3;
      if (pick < 70) begin
        w = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 60)) :
                                          16'($urandom_range(1, 6));
        h = 16'($urandom_range(1, 6));
        push_header(1'b1, w, h, dep, -1);
        push_packets(longint'(w) * longint'(h), nb, $urandom_range(0, 7) == 0, 1'b0);
      end else if (pick < 78) begin
        push_header(1'b1, 16'($urandom()), 16'($urandom()), 8'($urandom()),
                    $urandom_range(0, 11));
        push_noise($urandom_range(0, 4), 1000000);
      end else if (pick < 86) begin
        w   = 16'($urandom());
        h   = 16'($urandom());
        dep = 8'($urandom());
        case ($urandom_range(0, 2))
          0: w = '0;
          1: h = '0;
          default: while (dep == DEPTH_24 || dep == DEPTH_32) dep = 8'($urandom());
        endcase
        push_header(1'b1, w, h, dep, -1);
      end else if (pick < 93) begin
        w = 16'($urandom_range(1, 65535));
        h = 16'($urandom_range(1, 65535));
        push_header(1'b1, w, h, dep, -1);
        push_packets(longint'(w) * longint'(h), nb, 1'b0, 1'b1);
      end else begin
        push_noise($urandom_range(5, 30), 20);
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (pending_bytes.size() != 0 || in_tvalid);
    do @(negedge clk); while (awaited_results.size() != 0);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  // long receiver stall while the sender keeps offering bytes
  initial begin
    wait (bytes_sent >= 300);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (300) @(negedge clk);
    hold_off = 1'b0;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin : drive
    item_t acc;
    res_t  r;
    bit    got;
    if (!rst_n) begin
      decoder_clear();
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        acc.data_byte = in_tdata;
        acc.first     = in_tuser[0];
        decode_byte(acc, got, r);
        if (got) awaited_results.push_back(r);
        bytes_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= 23)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_bytes[0].data_byte;
          in_tuser  <= pending_bytes[0].first;
          void'(pending_bytes.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] seen);
    if (want !== seen) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result %0d: %s expected %0h, got %0h", results_seen, name, want, seen);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    res_t seen;
    res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen.kind        = out_tuser;
        seen.red         = out_tdata[7:0];
        seen.green       = out_tdata[15:8];
        seen.blue        = out_tdata[23:16];
        seen.alpha       = out_tdata[31:24];
        seen.repeat_res  = out_tdata[39:32];
        seen.pixel_index = out_tdata[71:40];
        seen.overrun     = out_tdata[72];
        seen.width       = out_tdata[88:73];
        seen.height      = out_tdata[104:89];
        seen.has_alpha   = out_tdata[105];
        seen.last        = out_tlast;
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: unexpected beat, kind %0d", results_seen, seen.kind);
          end
        end else begin
          want = awaited_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(seen.kind));
          check_field("red", 32'(want.red), 32'(seen.red));
          check_field("green", 32'(want.green), 32'(seen.green));
          check_field("blue", 32'(want.blue), 32'(seen.blue));
          check_field("alpha", 32'(want.alpha), 32'(seen.alpha));
          check_field("repeat", 32'(want.repeat_res), 32'(seen.repeat_res));
          check_field("pixel_index", want.pixel_index, seen.pixel_index);
          check_field("last", 32'(want.last), 32'(seen.last));
          check_field("overrun", 32'(want.overrun), 32'(seen.overrun));
          check_field("width", 32'(want.width), 32'(seen.width));
          check_field("height", 32'(want.height), 32'(seen.height));
          check_field("has_alpha", 32'(want.has_alpha), 32'(seen.has_alpha));
        end
        results_seen++;
      end
      out_tready <= !hold_off && (steady || $urandom_range(0, 99) >= 23);
    end
  end

endmodule
